// ===== rtl/core/fsr_pkg.sv =====
// Shared types and constants of the fax sample-to-pixel resampler.
package fsr_pkg;

  localparam int SAMPLE_W     = 8;
  localparam int COLUMN_W     = 11;
  localparam int ROW_W        = 16;
  localparam int VALUE_W      = 8;
  localparam int FORMAT_W     = 2;
  localparam int SPL_W        = 29;
  localparam int PPS_W        = 25;
  localparam int PPS_FRAC_BITS = 24;
  localparam int COUNT_W      = 32;
  localparam int ACCUM_W      = 48;
  localparam int SUM_W        = 20;
  localparam int CNT_W        = 12;
  localparam int QUOT_W       = 8;

  localparam int CFG_IDX_W    = 2;
  localparam int CFG_DATA_W   = 29;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FORMAT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SPL       = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PPS       = 2'd3;

  // output formats
  localparam logic [FORMAT_W-1:0] FMT_BIT  = 2'd0;
  localparam logic [FORMAT_W-1:0] FMT_GREY = 2'd1;
  localparam logic [FORMAT_W-1:0] FMT_INV  = 2'd2;

  localparam logic [FORMAT_W-1:0] FORMAT_RST    = FMT_GREY;
  localparam logic [VALUE_W-1:0]  THRESHOLD_RST = 8'd127;
  localparam logic [SPL_W-1:0]    SPL_RST       = 29'd262144000;
  localparam logic [PPS_W-1:0]    PPS_RST       = 25'd7591936;

  localparam logic [CNT_W-1:0] CNT_MAX = 12'd4095;
  localparam logic [ROW_W-1:0] ROW_MAX = 16'hFFFF;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/core/fsr_in_if.sv =====
// Sample channel: valid/ready handshake with sample and start flag.
interface fsr_in_if;
  logic                               valid;
  logic                               ready;
  logic [fsr_pkg::SAMPLE_W-1:0]       sample;
  logic                               start_image;

  modport source (output valid, output sample, output start_image, input ready);
  modport sink   (input valid, input sample, input start_image, output ready);
endinterface

// ===== rtl/core/fsr_out_if.sv =====
// Pixel channel: valid/ready handshake with column, row and value.
interface fsr_out_if;
  logic                               valid;
  logic                               ready;
  logic [fsr_pkg::COLUMN_W-1:0]       pixel_column;
  logic [fsr_pkg::ROW_W-1:0]          pixel_row;
  logic [fsr_pkg::VALUE_W-1:0]        pixel_value;

  modport source (output valid, output pixel_column, output pixel_row, output pixel_value,
                  input ready);
  modport sink   (input valid, input pixel_column, input pixel_row, input pixel_value,
                  output ready);
endinterface

// ===== rtl/core/fsr_avg_div.sv =====
// Iterative restoring divider for the column average, one quotient bit per cycle.
module fsr_avg_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [fsr_pkg::SUM_W-1:0]     dividend,
  input  logic [fsr_pkg::CNT_W-1:0]     divisor,
  output fsr_pkg::div_stat_t            stat,
  output logic [fsr_pkg::QUOT_W-1:0]    quotient
);

  logic [fsr_pkg::SUM_W-1:0]  rem;
  logic [fsr_pkg::CNT_W-1:0]  dvs;
  logic [2:0]                 step;
  logic                       busy;
  logic                       done;
  logic [fsr_pkg::SUM_W-1:0]  trial;
  logic                       fits;

  // sum <= 255 * count, so the quotient fits in eight bits
  assign trial = fsr_pkg::SUM_W'(dvs) << step;
  assign fits  = rem >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= 3'd0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= 3'd7;
      end else if (busy) begin
        if (step == 3'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          step <= step - 3'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      if (fits) begin
        rem <= rem - trial;
      end
      quotient[step] <= fits;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;

endmodule

// ===== rtl/core/fax_sample_to_pixel_resampler.sv =====
// Top level of the fax sample-to-pixel resampler.
//
// smp carries one demodulated brightness sample per transaction, with a
// start_image flag that restarts line timing before that sample. pix carries
// finished pixels (column, row, value). cfg_we/cfg_index/cfg_data write the
// format, threshold, line length and pixel ratio registers; the user must
// write them only while idle, as the block does not enforce it.
//
// A sample runs through a small sequencer: accept, row check, line-end
// rounding, 32x25 column multiply, column compare. A sample that stays in its
// column or opens the first column then returns to idle. A sample that closes
// a column starts an 8-step divider for the average, then waits for the pixel
// register; its pixel is loaded there as the sequencer returns to idle.
// smp.ready is high only while the sequencer is idle.
//
// Reset restores the register defaults and clears all line timing, the row
// counter and the pixel valid flag. If the receiver stalls, the pixel waits in
// the output register; a later pixel holds the sequencer until it is taken.
module fax_sample_to_pixel_resampler #(
  parameter int LINE_PIXELS    = 2048,
  parameter int LINE_FRAC_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  fsr_in_if.sink                            smp,
  fsr_out_if.source                         pix,
  input  logic                              cfg_we,
  input  logic [fsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fsr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int COL_W = $clog2(LINE_PIXELS);
  localparam int RND_W = fsr_pkg::ACCUM_W + 1 - LINE_FRAC_BITS;
  localparam int CMP_W = (RND_W > fsr_pkg::COUNT_W) ? RND_W : fsr_pkg::COUNT_W;
  localparam int PROD_W = fsr_pkg::COUNT_W + fsr_pkg::PPS_W;
  localparam int COLF_W = PROD_W - fsr_pkg::PPS_FRAC_BITS;
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(LINE_PIXELS - 1);
  localparam logic [fsr_pkg::ACCUM_W:0] HALF_M1 =
    (fsr_pkg::ACCUM_W+1)'((64'd1 << (LINE_FRAC_BITS - 1)) - 64'd1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROW  = 3'd1;
  localparam logic [2:0] S_RND  = 3'd2;
  localparam logic [2:0] S_MUL  = 3'd3;
  localparam logic [2:0] S_COL  = 3'd4;
  localparam logic [2:0] S_DIV  = 3'd5;
  localparam logic [2:0] S_EMIT = 3'd6;

  // configuration
  logic [fsr_pkg::FORMAT_W-1:0] output_format;
  logic [fsr_pkg::VALUE_W-1:0]  bit_threshold;
  logic [fsr_pkg::SPL_W-1:0]    samples_per_line;
  logic [fsr_pkg::PPS_W-1:0]    pixels_per_sample;

  // line state
  logic [2:0]                   state;
  logic [fsr_pkg::COUNT_W-1:0]  line_sample_count;
  logic [fsr_pkg::COUNT_W-1:0]  line_start_sample;
  logic [fsr_pkg::ACCUM_W-1:0]  line_end_accum;
  logic [RND_W-1:0]             line_end_rounded;
  logic                         line_end_neg;      // rounded line end is -1
  logic [fsr_pkg::ROW_W-1:0]    current_row;
  logic [COL_W-1:0]             previous_column;
  logic [fsr_pkg::SUM_W-1:0]    brightness_sum;
  logic [fsr_pkg::CNT_W-1:0]    sum_count;

  // per-sample working registers
  logic [fsr_pkg::SAMPLE_W-1:0] sample_q;
  logic [fsr_pkg::COUNT_W-1:0]  offset;
  logic [PROD_W-1:0]            prod;
  logic [COL_W-1:0]             column_pend;

  // pixel register
  logic                         pix_valid;
  logic [fsr_pkg::COLUMN_W-1:0] pix_column;
  logic [fsr_pkg::ROW_W-1:0]    pix_row;
  logic [fsr_pkg::VALUE_W-1:0]  pix_value;

  logic                         accept;
  logic [fsr_pkg::COUNT_W-1:0]  count_base;
  logic                         new_row;
  logic [fsr_pkg::ACCUM_W:0]    accum_sum;
  logic [fsr_pkg::ACCUM_W:0]    round_sum;
  logic [COLF_W-1:0]            column_full;
  logic [COL_W-1:0]             column;
  logic                         div_start;
  fsr_pkg::div_stat_t           div_st;
  logic [fsr_pkg::QUOT_W-1:0]   average;
  logic [fsr_pkg::VALUE_W-1:0]  value;
  logic                         pix_free;

  assign smp.ready  = (state == S_IDLE);
  assign accept     = smp.valid && smp.ready;
  assign count_base = smp.start_image ? '0 : line_sample_count;

  assign new_row   = line_end_neg ||
                     (CMP_W'(line_sample_count) > CMP_W'(line_end_rounded));
  assign accum_sum = {1'b0, line_end_accum} + (fsr_pkg::ACCUM_W+1)'(samples_per_line);
  assign round_sum = {1'b0, line_end_accum} + HALF_M1;

  assign column_full = prod[PROD_W-1:fsr_pkg::PPS_FRAC_BITS];
  assign column = (column_full > COLF_W'(LINE_PIXELS - 1)) ? COL_LAST
                : column_full[COL_W-1:0];

  assign div_start = (state == S_COL) && (column != previous_column) && (sum_count != '0);
  assign pix_free  = !pix_valid || pix.ready;

  fsr_avg_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (brightness_sum),
    .divisor  (sum_count),
    .stat     (div_st),
    .quotient (average)
  );

  always_comb begin
    case (output_format)
      fsr_pkg::FMT_BIT: value = {7'd0, (average > bit_threshold)};
      fsr_pkg::FMT_INV: value = 8'd255 - average;
      default:          value = average;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      output_format     <= fsr_pkg::FORMAT_RST;
      bit_threshold     <= fsr_pkg::THRESHOLD_RST;
      samples_per_line  <= fsr_pkg::SPL_RST;
      pixels_per_sample <= fsr_pkg::PPS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        fsr_pkg::REG_FORMAT:    output_format     <= cfg_data[fsr_pkg::FORMAT_W-1:0];
        fsr_pkg::REG_THRESHOLD: bit_threshold     <= cfg_data[fsr_pkg::VALUE_W-1:0];
        fsr_pkg::REG_SPL:       samples_per_line  <= cfg_data[fsr_pkg::SPL_W-1:0];
        fsr_pkg::REG_PPS:       pixels_per_sample <= cfg_data[fsr_pkg::PPS_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      line_sample_count <= '0;
      line_start_sample <= '0;
      line_end_accum    <= '0;
      line_end_rounded  <= '0;
      line_end_neg      <= 1'b1;
      current_row       <= '0;
      previous_column   <= '0;
      brightness_sum    <= '0;
      sum_count         <= '0;
      pix_valid         <= 1'b0;
    end else begin
      if (pix_valid && pix.ready) begin
        pix_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (smp.start_image) begin
              line_start_sample <= '0;
              line_end_accum    <= '0;
              line_end_neg      <= 1'b1;
              previous_column   <= '0;
              brightness_sum    <= '0;
              sum_count         <= '0;
            end
            line_sample_count <= (&count_base) ? count_base : count_base + 32'd1;
            state <= S_ROW;
          end
        end
        S_ROW: begin
          if (new_row) begin
            if (current_row != fsr_pkg::ROW_MAX) begin
              current_row <= current_row + 16'd1;
            end
            line_start_sample <= line_sample_count;
            line_end_accum    <= accum_sum[fsr_pkg::ACCUM_W] ? '1
                               : accum_sum[fsr_pkg::ACCUM_W-1:0];
            brightness_sum    <= '0;
            sum_count         <= '0;
          end
          state <= S_RND;
        end
        S_RND: begin
          // an unchanged line end rounds to the same value, so this runs always
          line_end_rounded <= RND_W'(round_sum >> LINE_FRAC_BITS);
          line_end_neg     <= 1'b0;
          state <= S_MUL;
        end
        S_MUL: begin
          state <= S_COL;
        end
        S_COL: begin
          if (column == previous_column) begin
            if (sum_count != fsr_pkg::CNT_MAX) begin
              brightness_sum <= brightness_sum + fsr_pkg::SUM_W'(sample_q);
              sum_count      <= sum_count + 12'd1;
            end
            state <= S_IDLE;
          end else if (sum_count != '0) begin
            state <= S_DIV;
          end else begin
            previous_column <= column;
            brightness_sum  <= fsr_pkg::SUM_W'(sample_q);
            sum_count       <= 12'd1;
            state <= S_IDLE;
          end
        end
        S_DIV: begin
          if (div_st.done) begin
            state <= S_EMIT;
          end
        end
        S_EMIT: begin
          if (pix_free) begin
            pix_valid       <= 1'b1;
            previous_column <= column_pend;
            brightness_sum  <= fsr_pkg::SUM_W'(sample_q);
            sum_count       <= 12'd1;
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // datapath registers, no reset
  always_ff @(posedge clk) begin
    if (accept) begin
      sample_q <= smp.sample;
    end
    if (state == S_RND) begin
      offset <= line_sample_count - line_start_sample;
    end
    if (state == S_MUL) begin
      prod <= {{fsr_pkg::PPS_W{1'b0}}, offset} * {{fsr_pkg::COUNT_W{1'b0}}, pixels_per_sample};
    end
    if (div_start) begin
      column_pend <= column;
    end
    if (state == S_EMIT && pix_free) begin
      pix_column <= fsr_pkg::COLUMN_W'(previous_column);
      pix_row    <= current_row;
      pix_value  <= value;
    end
  end

  assign pix.valid        = pix_valid;
  assign pix.pixel_column = pix_column;
  assign pix.pixel_row    = pix_row;
  assign pix.pixel_value  = pix_value;

`ifndef NO_ASSERTIONS
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    brightness_sum <= fsr_pkg::SUM_W'(sum_count) * 20'd255)
    else $error("brightness sum exceeds 255 per counted sample");

  a_div_done_state: assert property (@(posedge clk) disable iff (rst)
    div_st.done |-> state == S_DIV)
    else $error("divider finished outside the divide step");

  a_row_monotonic: assert property (@(posedge clk) disable iff (rst)
    1'b1 |=> current_row >= $past(current_row))
    else $error("row counter went backward");
`endif

endmodule
